@@ sv/oahi_pkg.sv @@
`default_nettype none
package oahi_pkg;

  typedef enum logic [1:0] {
    MODE_LINEAR    = 2'd0,
    MODE_QUADRATIC = 2'd1,
    MODE_DOUBLE    = 2'd2,
    MODE_SPARE     = 2'd3
  } probe_mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_SQ,
    ST_H2,
    ST_READ,
    ST_WAIT,
    ST_TEST,
    ST_STEP,
    ST_DONE
  } state_e;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned SlotW  = 12;
  localparam int unsigned SumW   = 24;
  localparam int unsigned ModeW  = 2;

endpackage
`default_nettype wire

@@ sv/open_addressing_hash_insert_unit.sv @@
`default_nettype none
// Sequence: a folding reduction of the key to its home slot, a squaring step, a second
// folding reduction of the square for the second hash, and the valid-RAM read; then a
// step, read, wait and test pass for each occupied slot met, until a free slot is found
// or the whole table has been probed. One key at a time: busy stays high
// until the done_o beat. Reset: asynchronous, active low; a clearing pass over
// every slot wipes the valid map first. The receiver cannot stall results.
module open_addressing_hash_insert_unit #(
  parameter int unsigned TABLE_SIZE = 4093
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   cfg_we_i,
  input  wire logic [oahi_pkg::ModeW-1:0] cfg_wdata_i,
  input  wire logic [oahi_pkg::KeyW-1:0]  key_i,
  output logic                        done_o,
  output logic [oahi_pkg::SlotW-1:0]  slot_o,
  output logic [oahi_pkg::SlotW-1:0]  probe_count_o,
  output logic                        table_full_o,
  output logic [oahi_pkg::SumW-1:0]   collision_total_o
);
  import oahi_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned MAW = (2 * IW > KeyW) ? 2 * IW : KeyW;
  localparam logic [IW-1:0] SizeI = IW'(TABLE_SIZE);
  localparam logic [SumW-1:0] SumMax = '1;

  state_e          state_q, state_d;
  logic [ModeW-1:0] mode_q;
  logic [KeyW-1:0] key_q, key_d;
  logic [IW-1:0]   home_q, home_d;
  logic [IW-1:0]   h2_q, h2_d;
  logic [IW-1:0]   off_q, off_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [IW-1:0]   i_q, i_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [MAW-1:0]  sq_q, sq_d;

  logic            done_q, done_d;
  logic [SlotW-1:0] slot_q, slot_d, pc_q, pc_d;
  logic            full_q, full_d;

  logic            mr_go;
  logic [MAW-1:0]  mr_a;
  logic            mr_done;
  logic [IW-1:0]   mr_rem;
  logic [2*IW-1:0] hsq;

  logic            vmem [TABLE_SIZE];
  logic [KeyW-1:0] kmem [TABLE_SIZE];
  logic            v_rd_q;
  logic            v_we;
  logic [AW-1:0]   v_wa;
  logic            v_wd;
  logic            k_we;

  logic [IW:0]     step_w, off_w, pos_w, sum_w;
  logic [IW-1:0]   step;

  oahi_modred #(.AW(MAW), .MW(IW), .M(TABLE_SIZE)) u_mod (
    .clk_i (clk_i), .rst_ni(rst_ni), .go_i(mr_go), .a_i(mr_a),
    .done_o(mr_done), .rem_o(mr_rem)
  );

  // key*key mod size equals home*home mod size
  assign hsq = (2*IW)'(mr_rem) * (2*IW)'(mr_rem);

  // probe offset increment: offset(i+1) - offset(i), reduced below size
  always_comb begin
    case (probe_mode_e'(mode_q))
      MODE_QUADRATIC: step_w = {i_q, 1'b1};
      MODE_DOUBLE:    step_w = {1'b0, h2_q};
      default:        step_w = (IW+1)'(1);
    endcase
    if (step_w >= {1'b0, SizeI}) step_w = step_w - {1'b0, SizeI};
    step = step_w[IW-1:0];
  end

  assign off_w = {1'b0, off_q} + {1'b0, step};
  assign pos_w = {1'b0, home_q} + {1'b0, off_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    key_d = key_q; home_d = home_q; h2_d = h2_q; off_d = off_q;
    pos_d = pos_q; i_d = i_q; clr_d = clr_q; sum_d = sum_q; sq_d = sq_q;
    done_d = 1'b0; slot_d = slot_q; pc_d = pc_q; full_d = full_q;
    mr_go = 1'b0; mr_a = sq_q;
    v_we = 1'b0; v_wa = clr_q[AW-1:0]; v_wd = 1'b0; k_we = 1'b0;
    sum_w = '0;
    case (state_q)
      ST_CLEAR: begin
        v_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == SizeI - 1'b1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          key_d = key_i;
          mr_go = 1'b1;
          mr_a = MAW'(key_i);
          state_d = ST_HOME;
        end
      end
      ST_HOME: begin
        if (mr_done) begin
          home_d = mr_rem;
          sq_d = MAW'(hsq);
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        mr_go = 1'b1;
        state_d = ST_H2;
      end
      ST_H2: begin
        if (mr_done) begin
          h2_d = (mr_rem == '0) ? IW'(1) : mr_rem;
          off_d = '0;
          i_d = '0;
          pos_d = home_q;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: state_d = ST_TEST;
      ST_TEST: begin
        if (!v_rd_q) begin
          v_we = 1'b1; v_wa = pos_q[AW-1:0]; v_wd = 1'b1; k_we = 1'b1;
          slot_d = SlotW'(pos_q); pc_d = SlotW'(i_q); full_d = 1'b0;
          sum_w = {1'b0, IW'(0)};
          state_d = ST_DONE;
        end else if (i_q == SizeI - 1'b1) begin
          slot_d = '0; pc_d = SlotW'(SizeI); full_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
        if (state_d == ST_DONE) begin
          sum_w = full_d ? {1'b0, SizeI} : {1'b0, i_q};
          if ({8'd0, sum_q} + 32'(sum_w) > 32'(SumMax)) sum_d = SumMax;
          else sum_d = sum_q + SumW'(sum_w);
        end
      end
      ST_STEP: begin
        off_d = (off_w >= {1'b0, SizeI}) ? IW'(off_w - {1'b0, SizeI}) : off_w[IW-1:0];
        i_d = i_q + 1'b1;
        state_d = ST_READ;
      end
      ST_DONE: begin
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_READ) begin
      pos_d = (pos_w >= {1'b0, SizeI}) ? IW'(pos_w - {1'b0, SizeI}) : pos_w[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q <= '0;
      clr_q <= '0;
      sum_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      clr_q <= clr_d;
      sum_q <= sum_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; home_q <= home_d; h2_q <= h2_d; off_q <= off_d;
    pos_q <= pos_d; i_q <= i_d; sq_q <= sq_d;
    slot_q <= slot_d; pc_q <= pc_d; full_q <= full_d;
  end

  // occupancy map and key store
  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_wa] <= v_wd;
    v_rd_q <= vmem[pos_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (k_we) kmem[pos_q[AW-1:0]] <= key_q;
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign slot_o = slot_q;
  assign probe_count_o = pc_q;
  assign table_full_o = full_q;
  assign collision_total_o = sum_q;
endmodule
`default_nettype wire

@@ sv/oahi_modred.sv @@
`default_nettype none
// Reduction by a constant modulus: 2^MW is congruent to R = 2^MW - M, so
// a = hi*2^MW + lo folds to hi*R + lo, one fold per cycle until hi is zero,
// then one compare and subtract.
module oahi_modred #(
  parameter int unsigned AW = 31,
  parameter int unsigned MW = 12,
  parameter int unsigned M  = 4093
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [AW-1:0] a_i,
  output logic               done_o,
  output logic [MW-1:0]      rem_o
);
  localparam logic [MW-1:0] ModM  = MW'(M);
  localparam logic [AW-1:0] FoldR = AW'((64'd1 << MW) - 64'(M));

  logic [AW-1:0] a_q, a_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [AW-1:0] fold;

  // fold the high part down, finish with one conditional subtract
  always_comb begin
    a_d    = a_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    fold   = AW'(a_q[AW-1:MW]) * FoldR + AW'(a_q[MW-1:0]);
    if (go_i) begin
      a_d   = a_i;
      run_d = 1'b1;
    end else if (run_q) begin
      if (a_q[AW-1:MW] != '0) begin
        a_d = fold;
      end else begin
        rem_d  = (a_q[MW-1:0] >= ModM) ? a_q[MW-1:0] - ModM : a_q[MW-1:0];
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire
